FILE: hdl/quaternion_rotate_vector_core_defines.svh
// Assertion macros shared by the quaternion rotation RTL.
`ifndef QUATERNION_ROTATE_VECTOR_CORE_DEFINES_SVH
`define QUATERNION_ROTATE_VECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define QRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrv assertion failed");
`define QRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrv assertion failed");
`else
`define QRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/qrv_pkg.sv
// Shared types and constants for the quaternion rotation core.
`timescale 1ns / 1ps

package qrv_pkg;

  localparam int QUAT_WIDTH = 16;

  typedef logic signed [QUAT_WIDTH-1:0] quat_t;

endpackage

FILE: hdl/qrv_if.sv
// Valid/ready channel interfaces for quaternion rotation input and result words.
`timescale 1ns / 1ps

interface qrv_in_if #(
  parameter int VEC_WIDTH = 24
) ();
  logic                        valid;
  logic                        ready;
  qrv_pkg::quat_t              quat_w;
  qrv_pkg::quat_t              quat_x;
  qrv_pkg::quat_t              quat_y;
  qrv_pkg::quat_t              quat_z;
  logic signed [VEC_WIDTH-1:0] vec_x;
  logic signed [VEC_WIDTH-1:0] vec_y;
  logic signed [VEC_WIDTH-1:0] vec_z;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

interface qrv_out_if #(
  parameter int VEC_WIDTH = 24
) ();
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] rot_x;
  logic signed [VEC_WIDTH-1:0] rot_y;
  logic signed [VEC_WIDTH-1:0] rot_z;
  logic                        saturated;

  modport source (
    output valid, rot_x, rot_y, rot_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, rot_x, rot_y, rot_z, saturated,
    output ready
  );
endinterface

FILE: hdl/quaternion_rotate_vector_core.sv
// Quaternion rotation core: five-stage pipeline computing q * (0,v) * conj(q).
// Rotates one vector per cycle: a new word is taken every clock while the
// result side keeps up, and each word passes through the stages below in order.
// Stage one forms the twelve quaternion-by-vector products, stage two sums
// and rounds them into the intermediate quaternion, stage three forms the
// twelve products with the conjugate, stage four sums and rounds again, and
// stage five saturates into the output register. Valid bits travel with the
// data and empty stages close up under a stall, so the input keeps taking
// words until every stage holds one. The quaternion is used as given (no
// normalization); a non-unit quaternion scales the result.
`timescale 1ns / 1ps
`include "quaternion_rotate_vector_core_defines.svh"

module quaternion_rotate_vector_core #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int VEC_WIDTH      = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  qrv_in_if.sink     in_ch,
  qrv_out_if.source  out_ch
);

  localparam int QW  = qrv_pkg::QUAT_WIDTH;
  localparam int VW  = VEC_WIDTH;
  localparam int F   = QUAT_FRAC_BITS;
  localparam int NS  = 5;
  localparam int M1W = QW + VW;
  localparam int S1W = (M1W + 3 > F + 2) ? M1W + 3 : F + 2;
  localparam int PWD = S1W - F;
  localparam int CW  = QW + 1;
  localparam int M2W = PWD + CW;
  localparam int S2W = (M2W + 3 > F + 2) ? M2W + 3 : F + 2;
  localparam int RW  = S2W - F;

  localparam logic signed [S1W-1:0] HALF1 = S1W'(1) << (F - 1);
  localparam logic signed [S2W-1:0] HALF2 = S2W'(1) << (F - 1);
  localparam logic signed [VW-1:0]  VMAX  = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0]  VMIN  = {1'b1, {(VW-1){1'b0}}};

  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] adv;

  logic signed [QW-1:0]  q0_r  [4];
  logic signed [QW-1:0]  q1_r  [4];
  logic signed [M1W-1:0] m0_r  [12];
  logic signed [S1W-1:0] sum1  [4];
  logic signed [PWD-1:0] p1_r  [4];
  logic signed [CW-1:0]  cq    [4];
  logic signed [M2W-1:0] m2_r  [12];
  logic signed [S2W-1:0] sum3  [3];
  logic signed [RW-1:0]  r3_r  [3];
  logic signed [VW-1:0]  rot_c [3];
  logic                  sat_c;
  logic signed [VW-1:0]  rot4_r [3];
  logic                  sat4_r;

  // stall control: a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = adv[0];

  // stage 1: q * v products
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      q0_r[0] <= in_ch.quat_w;
      q0_r[1] <= in_ch.quat_x;
      q0_r[2] <= in_ch.quat_y;
      q0_r[3] <= in_ch.quat_z;
      m0_r[0]  <= M1W'(in_ch.quat_x) * M1W'(in_ch.vec_x);
      m0_r[1]  <= M1W'(in_ch.quat_y) * M1W'(in_ch.vec_y);
      m0_r[2]  <= M1W'(in_ch.quat_z) * M1W'(in_ch.vec_z);
      m0_r[3]  <= M1W'(in_ch.quat_w) * M1W'(in_ch.vec_x);
      m0_r[4]  <= M1W'(in_ch.quat_y) * M1W'(in_ch.vec_z);
      m0_r[5]  <= M1W'(in_ch.quat_z) * M1W'(in_ch.vec_y);
      m0_r[6]  <= M1W'(in_ch.quat_w) * M1W'(in_ch.vec_y);
      m0_r[7]  <= M1W'(in_ch.quat_z) * M1W'(in_ch.vec_x);
      m0_r[8]  <= M1W'(in_ch.quat_x) * M1W'(in_ch.vec_z);
      m0_r[9]  <= M1W'(in_ch.quat_w) * M1W'(in_ch.vec_z);
      m0_r[10] <= M1W'(in_ch.quat_x) * M1W'(in_ch.vec_y);
      m0_r[11] <= M1W'(in_ch.quat_y) * M1W'(in_ch.vec_x);
    end
  end

  // stage 2: p = round(q * (0,v))
  always_comb begin
    sum1[0] = HALF1 - S1W'(m0_r[0]) - S1W'(m0_r[1]) - S1W'(m0_r[2]);
    sum1[1] = HALF1 + S1W'(m0_r[3]) + S1W'(m0_r[4]) - S1W'(m0_r[5]);
    sum1[2] = HALF1 + S1W'(m0_r[6]) + S1W'(m0_r[7]) - S1W'(m0_r[8]);
    sum1[3] = HALF1 + S1W'(m0_r[9]) + S1W'(m0_r[10]) - S1W'(m0_r[11]);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int k = 0; k < 4; k++) begin
        q1_r[k] <= q0_r[k];
        p1_r[k] <= PWD'(sum1[k] >>> F);
      end
    end
  end

  // stage 3: p * conj(q) products; negating the most negative part widens it
  always_comb begin
    cq[0] = CW'(q1_r[0]);
    cq[1] = -CW'(q1_r[1]);
    cq[2] = -CW'(q1_r[2]);
    cq[3] = -CW'(q1_r[3]);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      m2_r[0]  <= M2W'(p1_r[0]) * M2W'(cq[1]);
      m2_r[1]  <= M2W'(p1_r[1]) * M2W'(cq[0]);
      m2_r[2]  <= M2W'(p1_r[2]) * M2W'(cq[3]);
      m2_r[3]  <= M2W'(p1_r[3]) * M2W'(cq[2]);
      m2_r[4]  <= M2W'(p1_r[0]) * M2W'(cq[2]);
      m2_r[5]  <= M2W'(p1_r[2]) * M2W'(cq[0]);
      m2_r[6]  <= M2W'(p1_r[3]) * M2W'(cq[1]);
      m2_r[7]  <= M2W'(p1_r[1]) * M2W'(cq[3]);
      m2_r[8]  <= M2W'(p1_r[0]) * M2W'(cq[3]);
      m2_r[9]  <= M2W'(p1_r[3]) * M2W'(cq[0]);
      m2_r[10] <= M2W'(p1_r[1]) * M2W'(cq[2]);
      m2_r[11] <= M2W'(p1_r[2]) * M2W'(cq[1]);
    end
  end

  // stage 4: vector part of the second product, rounded
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum3[k] = HALF2 + S2W'(m2_r[4*k]) + S2W'(m2_r[4*k+1])
              + S2W'(m2_r[4*k+2]) - S2W'(m2_r[4*k+3]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int k = 0; k < 3; k++) begin
        r3_r[k] <= RW'(sum3[k] >>> F);
      end
    end
  end

  // stage 5: saturate into the output register
  qrv_sat #(
    .IN_W  (RW),
    .OUT_W (VW)
  ) u_sat (
    .r_in  (r3_r),
    .r_out (rot_c),
    .sat   (sat_c)
  );

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      rot4_r <= rot_c;
      sat4_r <= sat_c;
    end
  end

  assign out_ch.valid     = vld_r[NS-1];
  assign out_ch.rot_x     = rot4_r[0];
  assign out_ch.rot_y     = rot4_r[1];
  assign out_ch.rot_z     = rot4_r[2];
  assign out_ch.saturated = sat4_r;

  `QRV_ASSERT_NXT(a_enter_stage, clk, rst_n, in_ch.valid && in_ch.ready, vld_r[0])
  `QRV_ASSERT_IMP(a_ready_on_bubble, clk, rst_n, !(&vld_r), in_ch.ready)
  `QRV_ASSERT_NXT(a_mid_hold, clk, rst_n, vld_r[2] && !adv[2], vld_r[2])
  `QRV_ASSERT_IMP(a_sat_at_rail, clk, rst_n, out_ch.valid && out_ch.saturated,
                  rot4_r[0] == VMAX || rot4_r[0] == VMIN || rot4_r[1] == VMAX ||
                  rot4_r[1] == VMIN || rot4_r[2] == VMAX || rot4_r[2] == VMIN)

endmodule

FILE: hdl/qrv_sat.sv
// Three-lane signed saturation from the rounded result width to the vector width.
`timescale 1ns / 1ps

module qrv_sat #(
  parameter int IN_W  = 28,
  parameter int OUT_W = 24
) (
  input  logic signed [IN_W-1:0]  r_in  [3],
  output logic signed [OUT_W-1:0] r_out [3],
  output logic                    sat
);

  localparam logic signed [OUT_W-1:0] VMAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] VMIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic [2:0] ovf;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    if (IN_W > OUT_W) begin : g_clip
      logic [IN_W-OUT_W:0] top_bits;
      assign top_bits = r_in[i][IN_W-1:OUT_W-1];
      assign ovf[i]   = !((&top_bits) || (~|top_bits));
      assign r_out[i] = ovf[i] ? (r_in[i][IN_W-1] ? VMIN : VMAX) : r_in[i][OUT_W-1:0];
    end else begin : g_ext
      assign ovf[i]   = 1'b0;
      assign r_out[i] = OUT_W'(r_in[i]);
    end
  end

  assign sat = |ovf;

endmodule
